>>> rtl/sbeh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeh_pkg
// Shared types, codes and the heap ordering rule for the eviction heap.
// ----------------------------------------------------------------------------
package sbeh_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_USE    = 2'd1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_DUP      = 3'd4;

	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_FIT,
		S_ADD,
		S_RISE,
		S_SINK_A,
		S_SINK_B,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        wr;
		logic        clr;
		logic        bump;
		logic [31:0] key;
		logic [31:0] expiry;
		logic [31:0] size;
		logic [7:0]  inc;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] expiry;
		logic [31:0] use_cnt;
		logic [31:0] size;
	} view_t;

	function automatic logic precedes(input view_t a, input view_t b);
		logic r;
		if (a.expiry != b.expiry) begin
			r = a.expiry < b.expiry;
		end else begin
			r = a.use_cnt < b.use_cnt;
		end
		return r;
	endfunction

endpackage

>>> rtl/sbeh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeh_cell
// One directory slot: stores an entry, matches the lookup key and takes part
// in the first-free search passed along the row.
// ----------------------------------------------------------------------------
module sbeh_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sbeh_pkg::cmd_t    cmd,
	input  logic              sel,
	input  logic [31:0]       match_key,
	input  logic              free_in,
	output logic              free_out,
	output logic              first_free,
	output logic              hit,
	output sbeh_pkg::view_t   view
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [31:0] expiry_q;
	logic [31:0] use_q;
	logic [31:0] size_q;
	logic [32:0] use_sum;

	assign use_sum = {1'b0, use_q} + {25'd0, cmd.inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.wr) begin
			valid_q <= 1'b1;
		end else if (sel && cmd.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.wr) begin
			key_q    <= cmd.key;
			expiry_q <= cmd.expiry;
			size_q   <= cmd.size;
			use_q    <= '0;
		end else if (sel && cmd.bump) begin
			use_q <= use_sum[32] ? 32'hFFFF_FFFF : use_sum[31:0];
		end
	end

	assign hit        = valid_q && (key_q == match_key);
	assign first_free = !valid_q && !free_in;
	assign free_out   = free_in || !valid_q;

	assign view.valid   = valid_q;
	assign view.key     = key_q;
	assign view.expiry  = expiry_q;
	assign view.use_cnt = use_q;
	assign view.size    = size_q;

endmodule

>>> rtl/size_budget_eviction_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_budget_eviction_heap
// Cache directory with a binary min-heap on expiry and use count, a key
// lookup over a row of slot cells and a running size total under a budget.
// ----------------------------------------------------------------------------
// Flow: a query answers from the key lookup; an insert may evict first, then adds its entry and
// rises it level by level; an eviction removes the top entry and sinks the moved one; a use sinks.
// Throughput: one item at a time; a rise does one compare-and-swap step per cycle;
// a sink splits each step into child select, then swap; out_ready low stalls evictions and results.
// Reset: arst_n clears slot valid bits, entry count, total and control; the
// budget returns to 1048576. No clearing pass is needed.
module size_budget_eviction_heap #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] entry_key,
	input  logic [31:0] expiry_time,
	input  logic [31:0] entry_size,
	input  logic [7:0]  use_increment,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [31:0] evicted_key,
	output logic [2:0]  status,
	output logic        present,
	output logic [31:0] used_total,
	output logic        last
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = CW + 1;

	sbeh_pkg::state_t state_q, state_d;

	logic [31:0]   budget_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [31:0]   total_q, total_d;
	logic [IW-1:0] i_q, i_d, m_q, m_d;
	logic          ret_fit_q, ret_fit_d;
	logic [2:0]    stat_q, stat_d;
	logic          pres_q, pres_d;

	logic [1:0]    act_q;
	logic [31:0]   key_q, expiry_q, size_q;
	logic [7:0]    inc_q;

	logic [IW-1:0] heap_q [CAPACITY];
	logic [IW-1:0] pos_q  [CAPACITY];

	logic          hw_a, hw_b, pw_a, pw_b;
	logic [IW-1:0] ha_idx, ha_dat, hb_idx, hb_dat;
	logic [IW-1:0] pa_idx, pa_dat, pb_idx, pb_dat;

	sbeh_pkg::cmd_t  cmd;
	logic [IW-1:0]   sel_idx;
	logic            sel_en;
	sbeh_pkg::view_t slot_v [CAPACITY];
	logic [CAPACITY-1:0] hit_vec, ff_vec;
	logic [CAPACITY:0]   free_chain;
	logic                hit_any, free_any;
	logic [IW-1:0]       hit_idx, free_idx;

	logic        out_free, ld;
	logic        ld_kind, ld_last, ld_pres;
	logic [31:0] ld_key;
	logic [2:0]  ld_stat;

	logic [TW-1:0] l_w, r_w;
	logic [IW-1:0] p_idx, l_idx, r_idx, last_idx, top_slot;
	logic [32:0]   fit_sum;
	logic [31:0]   evict_size, total_sub;

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		sbeh_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.sel        (sel_en && (sel_idx == IW'(g))),
			.match_key  (key_q),
			.free_in    (free_chain[g]),
			.free_out   (free_chain[g+1]),
			.first_free (ff_vec[g]),
			.hit        (hit_vec[g]),
			.view       (slot_v[g])
		);
	end

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (hit_vec[k]) begin
				hit_idx = hit_idx | IW'(k);
			end
			if (ff_vec[k]) begin
				free_idx = free_idx | IW'(k);
			end
		end
	end

	assign hit_any  = |hit_vec;
	assign free_any = |ff_vec;

	assign out_free   = !out_valid || out_ready;
	assign in_ready   = (state_q == sbeh_pkg::S_IDLE);
	assign l_w        = TW'({i_q, 1'b1});
	assign r_w        = l_w + TW'(1);
	assign l_idx      = l_w[IW-1:0];
	assign r_idx      = r_w[IW-1:0];
	assign p_idx      = IW'((i_q - IW'(1)) >> 1);
	assign last_idx   = IW'(cnt_q - CW'(1));
	assign top_slot   = heap_q[0];
	assign fit_sum    = {1'b0, total_q} + {1'b0, size_q};
	assign evict_size = slot_v[top_slot].size;
	assign total_sub  = (total_q >= evict_size) ? (total_q - evict_size) : 32'd0;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		total_d   = total_q;
		i_d       = i_q;
		m_d       = m_q;
		ret_fit_d = ret_fit_q;
		stat_d    = stat_q;
		pres_d    = pres_q;
		cmd       = '0;
		cmd.key    = key_q;
		cmd.expiry = expiry_q;
		cmd.size   = size_q;
		cmd.inc    = inc_q;
		sel_idx   = '0;
		sel_en    = 1'b0;
		hw_a = 1'b0; hw_b = 1'b0; pw_a = 1'b0; pw_b = 1'b0;
		ha_idx = '0; ha_dat = '0; hb_idx = '0; hb_dat = '0;
		pa_idx = '0; pa_dat = '0; pb_idx = '0; pb_dat = '0;
		ld      = 1'b0;
		ld_kind = sbeh_pkg::KIND_DONE;
		ld_key  = '0;
		ld_stat = sbeh_pkg::ST_OK;
		ld_pres = 1'b0;
		ld_last = 1'b1;
		case (state_q)
			sbeh_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = sbeh_pkg::S_LOOK;
				end
			end
			sbeh_pkg::S_LOOK: begin
				if (act_q == sbeh_pkg::ACT_INSERT) begin
					if (hit_any) begin
						stat_d  = sbeh_pkg::ST_DUP;
						pres_d  = 1'b1;
						state_d = sbeh_pkg::S_DONE;
					end else if (cnt_q >= CW'(CAPACITY)) begin
						stat_d  = sbeh_pkg::ST_FULL;
						pres_d  = 1'b0;
						state_d = sbeh_pkg::S_DONE;
					end else begin
						state_d = sbeh_pkg::S_FIT;
					end
				end else if (act_q == sbeh_pkg::ACT_USE) begin
					if (!hit_any) begin
						stat_d  = sbeh_pkg::ST_NOTFOUND;
						pres_d  = 1'b0;
						state_d = sbeh_pkg::S_DONE;
					end else begin
						cmd.bump  = 1'b1;
						sel_idx   = hit_idx;
						sel_en    = 1'b1;
						i_d       = pos_q[hit_idx];
						ret_fit_d = 1'b0;
						stat_d    = sbeh_pkg::ST_OK;
						pres_d    = 1'b1;
						state_d   = sbeh_pkg::S_SINK_A;
					end
				end else begin
					stat_d  = hit_any ? sbeh_pkg::ST_OK : sbeh_pkg::ST_NOTFOUND;
					pres_d  = hit_any;
					state_d = sbeh_pkg::S_DONE;
				end
			end
			sbeh_pkg::S_FIT: begin
				if (fit_sum <= {1'b0, budget_q}) begin
					state_d = sbeh_pkg::S_ADD;
				end else if (cnt_q == '0) begin
					stat_d  = sbeh_pkg::ST_NOSPACE;
					pres_d  = 1'b0;
					state_d = sbeh_pkg::S_DONE;
				end else if (out_free) begin
					cmd.clr = 1'b1;
					sel_idx = top_slot;
					sel_en  = 1'b1;
					total_d = total_sub;
					cnt_d   = cnt_q - CW'(1);
					if (cnt_q > CW'(1)) begin
						hw_a   = 1'b1;
						ha_idx = '0;
						ha_dat = heap_q[last_idx];
						pw_a   = 1'b1;
						pa_idx = heap_q[last_idx];
						pa_dat = '0;
					end
					ld      = 1'b1;
					ld_kind = sbeh_pkg::KIND_EVICT;
					ld_key  = slot_v[top_slot].key;
					ld_last = 1'b0;
					if (cnt_q > CW'(2)) begin
						i_d       = '0;
						ret_fit_d = 1'b1;
						state_d   = sbeh_pkg::S_SINK_A;
					end
				end
			end
			sbeh_pkg::S_ADD: begin
				if (!free_any) begin
					stat_d  = sbeh_pkg::ST_FULL;
					pres_d  = 1'b0;
					state_d = sbeh_pkg::S_DONE;
				end else begin
					cmd.wr  = 1'b1;
					sel_idx = free_idx;
					sel_en  = 1'b1;
					hw_a    = 1'b1;
					ha_idx  = cnt_q[IW-1:0];
					ha_dat  = free_idx;
					pw_a    = 1'b1;
					pa_idx  = free_idx;
					pa_dat  = cnt_q[IW-1:0];
					cnt_d   = cnt_q + CW'(1);
					total_d = total_q + size_q;
					i_d     = cnt_q[IW-1:0];
					stat_d  = sbeh_pkg::ST_OK;
					pres_d  = 1'b1;
					state_d = sbeh_pkg::S_RISE;
				end
			end
			sbeh_pkg::S_RISE: begin
				if (i_q == '0) begin
					state_d = sbeh_pkg::S_DONE;
				end else if (sbeh_pkg::precedes(slot_v[heap_q[p_idx]],
						slot_v[heap_q[i_q]])) begin
					state_d = sbeh_pkg::S_DONE;
				end else begin
					hw_a = 1'b1; ha_idx = i_q;   ha_dat = heap_q[p_idx];
					hw_b = 1'b1; hb_idx = p_idx; hb_dat = heap_q[i_q];
					pw_a = 1'b1; pa_idx = heap_q[p_idx]; pa_dat = i_q;
					pw_b = 1'b1; pb_idx = heap_q[i_q];   pb_dat = p_idx;
					i_d  = p_idx;
				end
			end
			sbeh_pkg::S_SINK_A: begin
				if (l_w >= TW'(cnt_q)) begin
					state_d = ret_fit_q ? sbeh_pkg::S_FIT : sbeh_pkg::S_DONE;
				end else begin
					m_d = l_idx;
					if (r_w < TW'(cnt_q) && sbeh_pkg::precedes(slot_v[heap_q[r_idx]],
							slot_v[heap_q[l_idx]])) begin
						m_d = r_idx;
					end
					state_d = sbeh_pkg::S_SINK_B;
				end
			end
			sbeh_pkg::S_SINK_B: begin
				if (sbeh_pkg::precedes(slot_v[heap_q[i_q]], slot_v[heap_q[m_q]])) begin
					state_d = ret_fit_q ? sbeh_pkg::S_FIT : sbeh_pkg::S_DONE;
				end else begin
					hw_a = 1'b1; ha_idx = i_q; ha_dat = heap_q[m_q];
					hw_b = 1'b1; hb_idx = m_q; hb_dat = heap_q[i_q];
					pw_a = 1'b1; pa_idx = heap_q[m_q]; pa_dat = i_q;
					pw_b = 1'b1; pb_idx = heap_q[i_q]; pb_dat = m_q;
					i_d     = m_q;
					state_d = sbeh_pkg::S_SINK_A;
				end
			end
			sbeh_pkg::S_DONE: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_stat = stat_q;
					ld_pres = pres_q;
					state_d = sbeh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sbeh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sbeh_pkg::S_IDLE;
			budget_q  <= 32'd1048576;
			cnt_q     <= '0;
			total_q   <= '0;
			ret_fit_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			total_q   <= total_d;
			ret_fit_q <= ret_fit_d;
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			if (ld) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		m_q    <= m_d;
		stat_q <= stat_d;
		pres_q <= pres_d;
		if (in_valid && in_ready) begin
			act_q    <= action;
			key_q    <= entry_key;
			expiry_q <= expiry_time;
			size_q   <= entry_size;
			inc_q    <= use_increment;
		end
		if (hw_a) begin
			heap_q[ha_idx] <= ha_dat;
		end
		if (hw_b) begin
			heap_q[hb_idx] <= hb_dat;
		end
		if (pw_a) begin
			pos_q[pa_idx] <= pa_dat;
		end
		if (pw_b) begin
			pos_q[pb_idx] <= pb_dat;
		end
		if (ld) begin
			result_kind <= ld_kind;
			evicted_key <= ld_key;
			status      <= ld_stat;
			present     <= ld_pres;
			used_total  <= total_d;
			last        <= ld_last;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == result_kind))
		else $error("last flag disagrees with result kind");

	a_evict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == sbeh_pkg::KIND_EVICT) |->
		(status == sbeh_pkg::ST_OK && !present))
		else $error("eviction notice carries completion fields");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in progress");

endmodule
